// ----- src/mfps_pkg.sv -----
// Package for the maximum falling path sum block: sizes, payload types,
// register codes and the position record passed from sequencer to datapath.
// No dependencies.
package mfps_pkg;

  // matrix limits and derived index widths
  localparam int unsigned MAX_COLUMNS = 256;
  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W       = $clog2(MAX_ROWS);

  // payload and register widths
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned SUM_W      = 26;
  localparam int unsigned ROWCNT_W   = 11;
  localparam int unsigned COLCNT_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef logic signed [ELEM_W-1:0]     elem_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic        [COL_W-1:0]      col_t;
  typedef logic        [ROW_W-1:0]      row_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  // saturation limits of a path sum
  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } cfg_reg_e;

  // where an element sits in the matrix
  typedef struct packed {
    col_t col;
    logic first_row;
    logic last_row;
    logic last_col;
  } pos_t;

endpackage

// ----- src/mfps_if.sv -----
// Valid/ready channel interfaces of the maximum falling path sum block:
// element input, sum output and configuration write.
// Depends on mfps_pkg.
interface mfps_elem_if
  import mfps_pkg::*;
;
  logic  valid;
  logic  ready;
  elem_t element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface mfps_sum_if
  import mfps_pkg::*;
;
  logic valid;
  logic ready;
  sum_t best_path_sum;

  modport source (output valid, output best_path_sum, input ready);
  modport sink (input valid, input best_path_sum, output ready);
endinterface

interface mfps_cfg_if
  import mfps_pkg::*;
;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/max_falling_path_sum.sv -----
// Maximum falling path sum: takes one signed element per request, row by
// row, and after the last element of a row_count x column_count matrix
// returns the best path sum (start anywhere in the first row, step down,
// down-left or down-right). An element is taken every cycle while the result
// buffer has room; the datapath registers element, then result, and the
// best sums of the row above sit in a 256-entry RAM read one column ahead.
// A spare result register lets a new result wait behind one not yet taken,
// so the element side only waits while two results will be held after the
// coming edge. Writing either register restarts the matrix at row 0,
// column 0. Depends on mfps_pkg, mfps_if, mfps_ram, mfps_seq and mfps_core.
module max_falling_path_sum
  import mfps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  mfps_elem_if.sink          elem_i,
  mfps_sum_if.source         sum_o,
  mfps_cfg_if.sink           cfg_i
);

  logic accept;
  pos_t pos;
  col_t rd_addr;
  sum_t rd_data;
  logic wr_en;
  col_t wr_addr;
  sum_t wr_data;
  logic busy_result;

  // request acceptance: result buffer must have room next cycle
  assign elem_i.ready = !busy_result;
  assign accept       = elem_i.valid && elem_i.ready;
  assign cfg_i.ready  = 1'b1;

  mfps_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .accept_i    (accept),
    .pos_o       (pos),
    .rd_addr_o   (rd_addr)
  );

  // row store of best sums
  mfps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mfps_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .element_i     (elem_i.element_value),
    .pos_i         (pos),
    .rd_addr_i     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .busy_result_o (busy_result),
    .out_valid_o   (sum_o.valid),
    .out_ready_i   (sum_o.ready),
    .out_sum_o     (sum_o.best_path_sum)
  );

endmodule

// ----- src/mfps_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module mfps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/mfps_seq.sv -----
// Position sequencer: holds the row and column limits and walks the
// row/column position of the next element. Depends on mfps_pkg.
module mfps_seq
  import mfps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  cfg_idx_t  cfg_index_i,
  input  cfg_data_t cfg_data_i,
  input  logic      accept_i,
  output pos_t      pos_o,
  output col_t      rd_addr_o
);

  row_t row_last_q, row_last_d;
  col_t col_last_q, col_last_d;
  row_t row_pos_q, row_pos_d;
  col_t col_pos_q, col_pos_d;

  logic [ROWCNT_W-1:0] row_cnt;
  logic [ROWCNT_W-1:0] row_cnt_m1;
  logic [COLCNT_W-1:0] col_cnt;
  logic [COLCNT_W-1:0] col_cnt_m1;
  logic                last_row;
  logic                last_col;

  // clamp written counts into last-index form
  assign row_cnt    = cfg_data_i[ROWCNT_W-1:0];
  assign row_cnt_m1 = row_cnt - ROWCNT_W'(1);
  assign col_cnt    = cfg_data_i[COLCNT_W-1:0];
  assign col_cnt_m1 = col_cnt - COLCNT_W'(1);

  assign last_row = (row_pos_q == row_last_q);
  assign last_col = (col_pos_q == col_last_q);

  // register writes and position stepping
  always_comb begin
    row_last_d = row_last_q;
    col_last_d = col_last_q;
    row_pos_d  = row_pos_q;
    col_pos_d  = col_pos_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROW_COUNT: begin
          if (row_cnt == '0) begin
            row_last_d = '0;
          end else if (row_cnt > ROWCNT_W'(MAX_ROWS)) begin
            row_last_d = ROW_W'(MAX_ROWS - 1);
          end else begin
            row_last_d = row_cnt_m1[ROW_W-1:0];
          end
          row_pos_d = '0;
          col_pos_d = '0;
        end
        REG_COLUMN_COUNT: begin
          if (col_cnt == '0) begin
            col_last_d = '0;
          end else if (col_cnt > COLCNT_W'(MAX_COLUMNS)) begin
            col_last_d = COL_W'(MAX_COLUMNS - 1);
          end else begin
            col_last_d = col_cnt_m1[COL_W-1:0];
          end
          row_pos_d = '0;
          col_pos_d = '0;
        end
        default: begin
        end
      endcase
    end else if (accept_i) begin
      if (last_col) begin
        col_pos_d = '0;
        row_pos_d = last_row ? '0 : row_pos_q + ROW_W'(1);
      end else begin
        col_pos_d = col_pos_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_last_q <= '0;
      col_last_q <= '0;
      row_pos_q  <= '0;
      col_pos_q  <= '0;
    end else begin
      row_last_q <= row_last_d;
      col_last_q <= col_last_d;
      row_pos_q  <= row_pos_d;
      col_pos_q  <= col_pos_d;
    end
  end

  // current position and look-ahead read address (right neighbour)
  assign pos_o.col       = col_pos_q;
  assign pos_o.first_row = (row_pos_q == '0);
  assign pos_o.last_row  = last_row;
  assign pos_o.last_col  = last_col;
  assign rd_addr_o       = col_pos_q + COL_W'(1);

endmodule

// ----- src/mfps_core.sv -----
// Path sum datapath: element register, three-neighbour max and add with
// saturation, row store write, running last-row max and two-entry result buffer.
// Depends on mfps_pkg.
module mfps_core
  import mfps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  elem_t element_i,
  input  pos_t  pos_i,
  input  col_t  rd_addr_i,
  input  sum_t  rd_data_i,
  output logic  wr_en_o,
  output col_t  wr_addr_o,
  output sum_t  wr_data_o,
  output logic  busy_result_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output sum_t  out_sum_o
);

  logic  b_valid_q;
  elem_t b_x_q;
  pos_t  b_pos_q;

  sum_t first_q;
  sum_t ahead_q;
  sum_t left_q;
  sum_t last_best_q, last_best_d;
  logic fwd_hit_q;
  sum_t fwd_data_q;
  logic out_valid_q, out_valid_d;
  sum_t out_sum_q, out_sum_d;
  logic spare_valid_q, spare_valid_d;
  sum_t spare_sum_q, spare_sum_d;

  sum_t                  old_sum;
  sum_t                  right_sum;
  sum_t                  nb_best;
  logic signed [SUM_W:0] wide_sum;
  sum_t                  sat_sum;
  sum_t                  new_sum;
  logic                  make_result;

  // element register, loaded with every request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      b_x_q   <= element_i;
      b_pos_q <= pos_i;
    end
  end

  // neighbours from the row above
  assign old_sum   = (b_pos_q.col == '0) ? first_q : ahead_q;
  assign right_sum = fwd_hit_q ? fwd_data_q : rd_data_i;

  always_comb begin
    nb_best = old_sum;
    if ((b_pos_q.col != '0) && (left_q > nb_best)) begin
      nb_best = left_q;
    end
    if (!b_pos_q.last_col && (right_sum > nb_best)) begin
      nb_best = right_sum;
    end
  end

  // add and saturate
  assign wide_sum = (SUM_W+1)'(b_x_q) + (SUM_W+1)'(nb_best);

  always_comb begin
    if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
      sat_sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = wide_sum[SUM_W-1:0];
    end
  end

  assign new_sum = b_pos_q.first_row ? SUM_W'(b_x_q) : sat_sum;

  // row store write
  assign wr_en_o   = b_valid_q;
  assign wr_addr_o = b_pos_q.col;
  assign wr_data_o = new_sum;

  // running max over the last row
  always_comb begin
    last_best_d = last_best_q;
    if (b_valid_q && b_pos_q.last_row) begin
      if ((b_pos_q.col == '0) || (new_sum > last_best_q)) begin
        last_best_d = new_sum;
      end
    end
  end

  assign make_result = b_valid_q && b_pos_q.last_row && b_pos_q.last_col;

  // window registers and bypass of a write the look-ahead read missed
  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      left_q  <= old_sum;
      ahead_q <= right_sum;
      if (b_pos_q.col == '0) begin
        first_q <= new_sum;
      end
    end
    fwd_data_q <= new_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q   <= 1'b0;
      last_best_q <= '0;
    end else begin
      fwd_hit_q   <= b_valid_q && accept_i && (b_pos_q.col == rd_addr_i);
      last_best_q <= last_best_d;
    end
  end

  // result buffer: head drives the output, spare holds a result behind it
  always_comb begin
    out_valid_d   = out_valid_q;
    out_sum_d     = out_sum_q;
    spare_valid_d = spare_valid_q;
    spare_sum_d   = spare_sum_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d   = spare_valid_q;
      out_sum_d     = spare_sum_q;
      spare_valid_d = 1'b0;
    end
    if (make_result) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_sum_d   = last_best_d;
      end else begin
        spare_valid_d = 1'b1;
        spare_sum_d   = last_best_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q   <= out_sum_d;
    spare_sum_q <= spare_sum_d;
  end

  // a full buffer after this edge leaves no room for the next element's result
  assign busy_result_o = spare_valid_d;
  assign out_valid_o   = out_valid_q;
  assign out_sum_o     = out_sum_q;

endmodule
